// ===== hdl/boundary_tag_first_fit_allocator_assert.svh =====
// Assertion macros used by the allocator controller.
`ifndef BOUNDARY_TAG_FIRST_FIT_ALLOCATOR_ASSERT_SVH
`define BOUNDARY_TAG_FIRST_FIT_ALLOCATOR_ASSERT_SVH
`ifndef SYNTH
`define BTFF_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
`define BTFF_NEVER(lbl, clk, rstn, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) !(expr)) else $error(msg);
`else
`define BTFF_ASSERT(lbl, clk, rstn, prop, msg)
`define BTFF_NEVER(lbl, clk, rstn, expr, msg)
`endif
`endif

// ===== hdl/btff_pkg.sv =====
// Package with sizes, codes and interface types of the boundary tag allocator.
`timescale 1ns / 1ps
package btff_pkg;

    localparam int HEAP_BYTES      = 4096;
    localparam int TAG_WORDS       = HEAP_BYTES / 8;
    localparam int WIDX_W          = $clog2(TAG_WORDS);
    localparam int WCNT_W          = WIDX_W + 1;
    localparam int TAG_W           = $clog2(HEAP_BYTES + 1) + 1;
    localparam int SZW_W           = TAG_W - 3;
    localparam int REQ_W           = 13;
    localparam int NEED_W          = REQ_W - 2;
    localparam int CMP_W           = (NEED_W > SZW_W) ? NEED_W : SZW_W;
    localparam int SUM_W           = CMP_W + 1;
    localparam int ADDR_W          = 32;
    localparam int PADDR_W         = 3;
    localparam int MIN_SPLIT_WORDS = 3;

    typedef enum logic [4:0] {
        ST_INIT, ST_IH, ST_IT, ST_IDLE, ST_FAIL, ST_RD, ST_CHK,
        ST_AH, ST_AT, ST_A2H, ST_A2T, ST_FH, ST_FT, ST_RNX, ST_CNX,
        ST_MH, ST_MT, ST_PREV, ST_RPT, ST_CPT, ST_RP, ST_CP, ST_PH, ST_PT
    } state_t;

    typedef enum logic [3:0] {
        DP_NOP, DP_INIT, DP_START, DP_ADV, DP_FIT, DP_REST,
        DP_BLK, DP_NX, DP_PS, DP_PREV
    } dp_op_t;

    typedef enum logic [1:0] {
        RA_W, RA_NX, RA_PT, RA_P
    } rd_sel_t;

    typedef enum logic {
        WA_HEAD, WA_TAIL
    } wr_sel_t;

    typedef enum logic {
        OP_ALLOC = 1'b0,
        OP_FREE  = 1'b1
    } opcode_t;

    typedef struct packed {
        dp_op_t  op;
        rd_sel_t rd_sel;
        logic    wr_en;
        wr_sel_t wr_sel;
        logic    wr_used;
        logic    finish;
        logic    grant;
        logic    with_addr;
    } cmd_t;

    typedef struct packed {
        logic addr_ok;
        logic sane;
        logic fits;
        logic at_end;
        logic rd_used;
        logic w_lt_tgt;
        logic w_eq_tgt;
        logic nx_in;
        logic nx_sane;
        logic w_zero;
        logic ps_ok;
        logic p_match;
        logic split;
    } status_t;

endpackage

// ===== hdl/btff_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module btff_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== hdl/btff_datapath.sv =====
// Datapath: tag memory, block cursor registers, compare logic and result registers.
`timescale 1ns / 1ps
module btff_datapath (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  btff_pkg::cmd_t                       cmd,
    input  logic [btff_pkg::REQ_W-1:0]           request_size,
    input  logic [btff_pkg::ADDR_W-1:0]          free_address,
    input  logic [btff_pkg::ADDR_W-1:0]          heap_base,
    output btff_pkg::status_t                    status,
    output logic                                 done,
    output logic                                 granted,
    output logic [btff_pkg::ADDR_W-1:0]          payload_address
);

    localparam int WCNT_W = btff_pkg::WCNT_W;
    localparam int WIDX_W = btff_pkg::WIDX_W;
    localparam int SZW_W  = btff_pkg::SZW_W;
    localparam int CMP_W  = btff_pkg::CMP_W;
    localparam int SUM_W  = btff_pkg::SUM_W;
    localparam int NEED_W = btff_pkg::NEED_W;
    localparam int REQ_W  = btff_pkg::REQ_W;
    localparam int ADDR_W = btff_pkg::ADDR_W;
    localparam int TAG_W  = btff_pkg::TAG_W;

    logic [WCNT_W-1:0] w_reg, w_next;
    logic [SZW_W-1:0]  s_reg, s_next;
    logic [SZW_W-1:0]  rest_reg, rest_next;
    logic [NEED_W-1:0] need_reg, need_next;
    logic [WIDX_W-1:0] tgt_reg, tgt_next;
    logic              split_reg, split_next;
    logic [ADDR_W-1:0] res_addr_reg, res_addr_next;
    logic              done_reg, done_next;
    logic              granted_reg, granted_next;
    logic [ADDR_W-1:0] payload_address_reg, payload_address_next;

    logic [TAG_W-1:0]  rdata;
    logic [TAG_W-1:0]  wdata;
    logic [WIDX_W-1:0] raddr;
    logic [WIDX_W-1:0] waddr;
    logic [SZW_W-1:0]  rd_words;
    logic              rd_used;
    logic [WCNT_W-1:0] room;
    logic [WCNT_W-1:0] nx_room;
    logic [SUM_W-1:0]  nx_sum;
    logic [SUM_W-1:0]  adv_sum;
    logic [SZW_W-1:0]  rest_d;
    logic [WCNT_W-1:0] w_prev;
    logic [WCNT_W-1:0] w_minus1;
    logic [SUM_W-1:0]  tail_pos;
    logic [ADDR_W-1:0] offset;
    logic [REQ_W:0]    req_sum;
    logic [NEED_W-1:0] need_d;

    btff_ram #(
        .WIDTH(TAG_W),
        .DEPTH(btff_pkg::TAG_WORDS)
    ) u_tags (
        .clk  (clk),
        .we   (cmd.wr_en),
        .waddr(waddr),
        .wdata(wdata),
        .raddr(raddr),
        .rdata(rdata)
    );

    assign rd_words = rdata[TAG_W-1:3];
    assign rd_used  = rdata[0];
    assign room     = WCNT_W'(btff_pkg::TAG_WORDS) - w_reg;
    assign nx_sum   = SUM_W'(w_reg) + SUM_W'(s_reg);
    assign nx_room  = WCNT_W'(btff_pkg::TAG_WORDS) - WCNT_W'(nx_sum);
    assign adv_sum  = SUM_W'(w_reg) + SUM_W'(rd_words);
    assign rest_d   = rd_words - SZW_W'(need_reg);
    assign w_prev   = w_reg - WCNT_W'(rest_reg);
    assign w_minus1 = w_reg - WCNT_W'(1);
    assign tail_pos = nx_sum - SUM_W'(1);
    assign offset   = free_address - heap_base - ADDR_W'(8);
    assign req_sum  = (REQ_W + 1)'(request_size) + (REQ_W + 1)'(7);
    assign need_d   = NEED_W'(req_sum[REQ_W:3]) + NEED_W'(2);

    always_comb
    begin
        status.addr_ok  = (offset[2:0] == 3'b000)
                          && (offset < ADDR_W'(btff_pkg::HEAP_BYTES));
        status.sane     = (rd_words != '0) && (CMP_W'(rd_words) <= CMP_W'(room));
        status.fits     = !rd_used && (CMP_W'(rd_words) >= CMP_W'(need_reg));
        status.at_end   = (adv_sum == SUM_W'(btff_pkg::TAG_WORDS));
        status.rd_used  = rd_used;
        status.w_lt_tgt = (w_reg < WCNT_W'(tgt_reg));
        status.w_eq_tgt = (w_reg == WCNT_W'(tgt_reg));
        status.nx_in    = (nx_sum < SUM_W'(btff_pkg::TAG_WORDS));
        status.nx_sane  = (rd_words != '0) && (CMP_W'(rd_words) <= CMP_W'(nx_room));
        status.w_zero   = (w_reg == '0);
        status.ps_ok    = (rd_words != '0) && (CMP_W'(rd_words) <= CMP_W'(w_reg));
        status.p_match  = (rd_words == rest_reg);
        status.split    = split_reg;
    end

    always_comb
    begin
        case (cmd.rd_sel)
            btff_pkg::RA_W:  raddr = w_reg[WIDX_W-1:0];
            btff_pkg::RA_NX: raddr = nx_sum[WIDX_W-1:0];
            btff_pkg::RA_PT: raddr = w_minus1[WIDX_W-1:0];
            btff_pkg::RA_P:  raddr = w_prev[WIDX_W-1:0];
            default:         raddr = w_reg[WIDX_W-1:0];
        endcase
    end

    assign waddr = (cmd.wr_sel == btff_pkg::WA_TAIL) ? tail_pos[WIDX_W-1:0]
                                                     : w_reg[WIDX_W-1:0];
    assign wdata = {s_reg, 2'b00, cmd.wr_used};

    always_comb
    begin
        w_next        = w_reg;
        s_next        = s_reg;
        rest_next     = rest_reg;
        need_next     = need_reg;
        tgt_next      = tgt_reg;
        split_next    = split_reg;
        res_addr_next = res_addr_reg;
        case (cmd.op)
            btff_pkg::DP_INIT:
            begin
                w_next = '0;
                s_next = SZW_W'(btff_pkg::TAG_WORDS);
            end
            btff_pkg::DP_START:
            begin
                w_next    = '0;
                need_next = need_d;
                tgt_next  = offset[WIDX_W+2:3];
            end
            btff_pkg::DP_ADV:
            begin
                w_next = WCNT_W'(adv_sum);
            end
            btff_pkg::DP_FIT:
            begin
                split_next    = (rest_d >= SZW_W'(btff_pkg::MIN_SPLIT_WORDS));
                s_next        = split_next ? SZW_W'(need_reg) : rd_words;
                rest_next     = rest_d;
                res_addr_next = heap_base + ADDR_W'({w_reg, 3'b000}) + ADDR_W'(8);
            end
            btff_pkg::DP_REST:
            begin
                w_next = WCNT_W'(nx_sum);
                s_next = rest_reg;
            end
            btff_pkg::DP_BLK:
            begin
                s_next = rd_words;
            end
            btff_pkg::DP_NX:
            begin
                s_next = s_reg + rd_words;
            end
            btff_pkg::DP_PS:
            begin
                rest_next = rd_words;
            end
            btff_pkg::DP_PREV:
            begin
                w_next = w_prev;
                s_next = s_reg + rest_reg;
            end
            default:
            begin
                w_next = w_reg;
            end
        endcase
    end

    always_comb
    begin
        done_next            = cmd.finish;
        granted_next         = granted_reg;
        payload_address_next = payload_address_reg;
        if (cmd.finish)
        begin
            granted_next         = cmd.grant;
            payload_address_next = cmd.with_addr ? res_addr_reg : '0;
        end
    end

    always_ff @(posedge clk)
    begin
        w_reg               <= w_next;
        s_reg               <= s_next;
        rest_reg            <= rest_next;
        need_reg            <= need_next;
        tgt_reg             <= tgt_next;
        split_reg           <= split_next;
        res_addr_reg        <= res_addr_next;
        granted_reg         <= granted_next;
        payload_address_reg <= payload_address_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= done_next;
        end
    end

    assign done            = done_reg;
    assign granted         = granted_reg;
    assign payload_address = payload_address_reg;

endmodule

// ===== hdl/btff_controller.sv =====
// Controller: sequences the tag walks, splits and merges of each request.
`timescale 1ns / 1ps
`include "boundary_tag_first_fit_allocator_assert.svh"
module btff_controller (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic               opcode,
    input  btff_pkg::status_t  status,
    output btff_pkg::cmd_t     cmd,
    output logic               busy
);

    btff_pkg::state_t state_reg, state_next;
    logic             op_reg, op_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= btff_pkg::ST_INIT;
            op_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            op_reg    <= op_next;
        end
    end

    always_comb
    begin
        state_next    = state_reg;
        op_next       = op_reg;
        cmd.op        = btff_pkg::DP_NOP;
        cmd.rd_sel    = btff_pkg::RA_W;
        cmd.wr_en     = 1'b0;
        cmd.wr_sel    = btff_pkg::WA_HEAD;
        cmd.wr_used   = 1'b0;
        cmd.finish    = 1'b0;
        cmd.grant     = 1'b0;
        cmd.with_addr = 1'b0;
        case (state_reg)
            // After reset one free block covering the heap is written.
            btff_pkg::ST_INIT:
            begin
                cmd.op     = btff_pkg::DP_INIT;
                state_next = btff_pkg::ST_IH;
            end
            btff_pkg::ST_IH:
            begin
                cmd.wr_en  = 1'b1;
                state_next = btff_pkg::ST_IT;
            end
            btff_pkg::ST_IT:
            begin
                cmd.wr_en  = 1'b1;
                cmd.wr_sel = btff_pkg::WA_TAIL;
                state_next = btff_pkg::ST_IDLE;
            end
            btff_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    cmd.op  = btff_pkg::DP_START;
                    op_next = opcode;
                    if (opcode == btff_pkg::OP_FREE && !status.addr_ok)
                    begin
                        state_next = btff_pkg::ST_FAIL;
                    end
                    else
                    begin
                        state_next = btff_pkg::ST_RD;
                    end
                end
            end
            btff_pkg::ST_FAIL:
            begin
                cmd.finish = 1'b1;
                state_next = btff_pkg::ST_IDLE;
            end
            btff_pkg::ST_RD:
            begin
                state_next = btff_pkg::ST_CHK;
            end
            btff_pkg::ST_CHK:
            begin
                if (op_reg == btff_pkg::OP_ALLOC)
                begin
                    if (!status.sane)
                    begin
                        cmd.finish = 1'b1;
                        state_next = btff_pkg::ST_IDLE;
                    end
                    else if (status.fits)
                    begin
                        cmd.op     = btff_pkg::DP_FIT;
                        state_next = btff_pkg::ST_AH;
                    end
                    else if (status.at_end)
                    begin
                        cmd.finish = 1'b1;
                        state_next = btff_pkg::ST_IDLE;
                    end
                    else
                    begin
                        cmd.op     = btff_pkg::DP_ADV;
                        state_next = btff_pkg::ST_RD;
                    end
                end
                else
                begin
                    if (status.w_lt_tgt)
                    begin
                        if (!status.sane)
                        begin
                            cmd.finish = 1'b1;
                            state_next = btff_pkg::ST_IDLE;
                        end
                        else
                        begin
                            cmd.op     = btff_pkg::DP_ADV;
                            state_next = btff_pkg::ST_RD;
                        end
                    end
                    else if (!status.w_eq_tgt || !status.rd_used || !status.sane)
                    begin
                        cmd.finish = 1'b1;
                        state_next = btff_pkg::ST_IDLE;
                    end
                    else
                    begin
                        cmd.op     = btff_pkg::DP_BLK;
                        state_next = btff_pkg::ST_FH;
                    end
                end
            end
            btff_pkg::ST_AH:
            begin
                cmd.wr_en   = 1'b1;
                cmd.wr_used = 1'b1;
                state_next  = btff_pkg::ST_AT;
            end
            btff_pkg::ST_AT:
            begin
                cmd.wr_en   = 1'b1;
                cmd.wr_sel  = btff_pkg::WA_TAIL;
                cmd.wr_used = 1'b1;
                if (status.split)
                begin
                    cmd.op     = btff_pkg::DP_REST;
                    state_next = btff_pkg::ST_A2H;
                end
                else
                begin
                    cmd.finish    = 1'b1;
                    cmd.grant     = 1'b1;
                    cmd.with_addr = 1'b1;
                    state_next    = btff_pkg::ST_IDLE;
                end
            end
            btff_pkg::ST_A2H:
            begin
                cmd.wr_en  = 1'b1;
                state_next = btff_pkg::ST_A2T;
            end
            btff_pkg::ST_A2T:
            begin
                cmd.wr_en     = 1'b1;
                cmd.wr_sel    = btff_pkg::WA_TAIL;
                cmd.finish    = 1'b1;
                cmd.grant     = 1'b1;
                cmd.with_addr = 1'b1;
                state_next    = btff_pkg::ST_IDLE;
            end
            btff_pkg::ST_FH:
            begin
                cmd.wr_en  = 1'b1;
                state_next = btff_pkg::ST_FT;
            end
            btff_pkg::ST_FT:
            begin
                cmd.wr_en  = 1'b1;
                cmd.wr_sel = btff_pkg::WA_TAIL;
                state_next = status.nx_in ? btff_pkg::ST_RNX : btff_pkg::ST_PREV;
            end
            btff_pkg::ST_RNX:
            begin
                cmd.rd_sel = btff_pkg::RA_NX;
                state_next = btff_pkg::ST_CNX;
            end
            btff_pkg::ST_CNX:
            begin
                if (status.nx_sane && !status.rd_used)
                begin
                    cmd.op     = btff_pkg::DP_NX;
                    state_next = btff_pkg::ST_MH;
                end
                else
                begin
                    state_next = btff_pkg::ST_PREV;
                end
            end
            btff_pkg::ST_MH:
            begin
                cmd.wr_en  = 1'b1;
                state_next = btff_pkg::ST_MT;
            end
            btff_pkg::ST_MT:
            begin
                cmd.wr_en  = 1'b1;
                cmd.wr_sel = btff_pkg::WA_TAIL;
                state_next = btff_pkg::ST_PREV;
            end
            btff_pkg::ST_PREV:
            begin
                if (status.w_zero)
                begin
                    cmd.finish = 1'b1;
                    cmd.grant  = 1'b1;
                    state_next = btff_pkg::ST_IDLE;
                end
                else
                begin
                    state_next = btff_pkg::ST_RPT;
                end
            end
            btff_pkg::ST_RPT:
            begin
                cmd.rd_sel = btff_pkg::RA_PT;
                state_next = btff_pkg::ST_CPT;
            end
            btff_pkg::ST_CPT:
            begin
                if (status.ps_ok)
                begin
                    cmd.op     = btff_pkg::DP_PS;
                    state_next = btff_pkg::ST_RP;
                end
                else
                begin
                    cmd.finish = 1'b1;
                    cmd.grant  = 1'b1;
                    state_next = btff_pkg::ST_IDLE;
                end
            end
            btff_pkg::ST_RP:
            begin
                cmd.rd_sel = btff_pkg::RA_P;
                state_next = btff_pkg::ST_CP;
            end
            btff_pkg::ST_CP:
            begin
                if (!status.rd_used && status.p_match)
                begin
                    cmd.op     = btff_pkg::DP_PREV;
                    state_next = btff_pkg::ST_PH;
                end
                else
                begin
                    cmd.finish = 1'b1;
                    cmd.grant  = 1'b1;
                    state_next = btff_pkg::ST_IDLE;
                end
            end
            btff_pkg::ST_PH:
            begin
                cmd.wr_en  = 1'b1;
                state_next = btff_pkg::ST_PT;
            end
            btff_pkg::ST_PT:
            begin
                cmd.wr_en  = 1'b1;
                cmd.wr_sel = btff_pkg::WA_TAIL;
                cmd.finish = 1'b1;
                cmd.grant  = 1'b1;
                state_next = btff_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = btff_pkg::ST_INIT;
            end
        endcase
    end

    assign busy = (state_reg != btff_pkg::ST_IDLE);

    `BTFF_NEVER(a_no_write_idle, clk, rst_n, (state_reg == btff_pkg::ST_IDLE) && cmd.wr_en, "tag write while idle")
    `BTFF_ASSERT(a_finish_to_idle, clk, rst_n, cmd.finish |=> (state_reg == btff_pkg::ST_IDLE), "request finished without returning to idle")
    `BTFF_ASSERT(a_accept_busy, clk, rst_n, (start && !busy) |=> busy, "accepted request did not raise busy")

endmodule

// ===== hdl/boundary_tag_first_fit_allocator.sv =====
// Top level: configuration register port, controller and datapath of the allocator.
`timescale 1ns / 1ps
// First-fit heap allocator with boundary tags held in a 512-word tag memory.
// A request is taken when start is high and busy is low; its single result
// appears for one cycle with done high and cannot be held off. An allocate
// visits blocks from the heap start with one tag memory read and one check
// per block. A granted allocate then writes the head and tail tags of its
// block, and of the split-off rest if there is one. A free walks to its block
// the same way and then performs the release and both merges. After reset the
// block is busy while it writes the initial free block. The user must see that
// heap_base is written through the register port only while the block is idle;
// the block itself does not enforce this.
module boundary_tag_first_fit_allocator (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic                                opcode,
    input  logic [btff_pkg::REQ_W-1:0]          request_size,
    input  logic [btff_pkg::ADDR_W-1:0]         free_address,
    output logic                                done,
    output logic                                granted,
    output logic [btff_pkg::ADDR_W-1:0]         payload_address,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [btff_pkg::PADDR_W-1:0]        paddr,
    input  logic [31:0]                         pwdata,
    output logic [31:0]                         prdata,
    output logic                                pready
);

    logic [btff_pkg::ADDR_W-1:0] heap_base_reg, heap_base_next;
    btff_pkg::cmd_t              cmd;
    btff_pkg::status_t           status;
    logic                        hit_base;

    assign hit_base = (paddr[btff_pkg::PADDR_W-1] == 1'b0);
    assign pready   = 1'b1;
    assign prdata   = hit_base ? heap_base_reg : 32'd0;

    always_comb
    begin
        heap_base_next = heap_base_reg;
        if (psel && penable && pwrite && hit_base)
        begin
            heap_base_next = pwdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            heap_base_reg <= '0;
        end
        else
        begin
            heap_base_reg <= heap_base_next;
        end
    end

    btff_controller u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .opcode(opcode),
        .status(status),
        .cmd   (cmd),
        .busy  (busy)
    );

    btff_datapath u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .request_size   (request_size),
        .free_address   (free_address),
        .heap_base      (heap_base_reg),
        .status         (status),
        .done           (done),
        .granted        (granted),
        .payload_address(payload_address)
    );

endmodule

// ===== bench/tb_boundary_tag_first_fit_allocator.sv =====
// Self-checking testbench for the boundary tag first-fit allocator.
`timescale 1ns / 1ps
module tb_boundary_tag_first_fit_allocator;

    localparam int CYCLE_LIMIT = 1000000;
    localparam int SETTLE      = 40;

    // Keeps its own copy of the tag memory and the expected responses in order.
    class alloc_scoreboard;
        bit [btff_pkg::TAG_W-1:0]  tags [btff_pkg::TAG_WORDS];
        bit [btff_pkg::ADDR_W-1:0] base;
        bit                        granted_q [$];
        bit [btff_pkg::ADDR_W-1:0] address_q [$];
        int                        errors;

        function void clear_heap();
            foreach (tags[i])
            begin
                tags[i] = '0;
            end
            put_tags(0, btff_pkg::HEAP_BYTES, 1'b0);
        endfunction

        function int unsigned size_at(int unsigned w);
            if (w >= btff_pkg::TAG_WORDS) return 0;
            return int'(tags[w]) & ~7;
        endfunction

        function bit used_at(int unsigned w);
            if (w >= btff_pkg::TAG_WORDS) return 1'b1;
            return tags[w][0];
        endfunction

        function void put_tags(int unsigned w, int unsigned size, bit used);
            int unsigned last;
            last = w + size / 8 - 1;
            if (w < btff_pkg::TAG_WORDS) tags[w] = btff_pkg::TAG_W'(size | used);
            if (size >= 8 && last < btff_pkg::TAG_WORDS)
                tags[last] = btff_pkg::TAG_W'(size | used);
        endfunction

        function int unsigned sane_size(int unsigned w);
            int unsigned s;
            s = size_at(w);
            if (s < 8 || s / 8 > btff_pkg::TAG_WORDS - w) return 0;
            return s;
        endfunction

        function void allocate(bit [btff_pkg::REQ_W-1:0] req, output bit g,
                               output bit [btff_pkg::ADDR_W-1:0] a);
            int unsigned need, w, s, rest;
            need = ((int'(req) + 7) & ~7) + 16;
            w = 0;
            g = 1'b0;
            a = '0;
            while (w < btff_pkg::TAG_WORDS)
            begin
                s = sane_size(w);
                if (s == 0) break;
                if (s >= need && !used_at(w))
                begin
                    rest = s - need;
                    if (rest >= 8 * btff_pkg::MIN_SPLIT_WORDS)
                    begin
                        put_tags(w, need, 1'b1);
                        put_tags(w + need / 8, rest, 1'b0);
                    end
                    else
                    begin
                        put_tags(w, s, 1'b1);
                    end
                    g = 1'b1;
                    a = base + btff_pkg::ADDR_W'(w * 8 + 8);
                    return;
                end
                w += s / 8;
            end
        endfunction

        function bit release_block(bit [btff_pkg::ADDR_W-1:0] addr);
            bit [btff_pkg::ADDR_W-1:0] off;
            int unsigned target, w, s, bs, nx, ns, ps, p;
            off = addr - base - 32'd8;
            if (off[2:0] != 3'b0 || off >= btff_pkg::HEAP_BYTES) return 1'b0;
            target = off / 8;
            w = 0;
            while (w < target)
            begin
                bs = sane_size(w);
                if (bs == 0) return 1'b0;
                w += bs / 8;
            end
            if (w != target || !used_at(w)) return 1'b0;
            s = sane_size(w);
            if (s == 0) return 1'b0;
            put_tags(w, s, 1'b0);
            if (w + s / 8 < btff_pkg::TAG_WORDS)
            begin
                nx = w + s / 8;
                ns = sane_size(nx);
                if (ns != 0 && !used_at(nx))
                begin
                    s += ns;
                    put_tags(w, s, 1'b0);
                end
            end
            if (w != 0)
            begin
                ps = size_at(w - 1);
                if (ps >= 8 && ps / 8 <= w)
                begin
                    p = w - ps / 8;
                    if (!used_at(p) && size_at(p) == ps) put_tags(p, ps + s, 1'b0);
                end
            end
            return 1'b1;
        endfunction

        function void note_request(btff_pkg::opcode_t op, bit [btff_pkg::REQ_W-1:0] req,
                                   bit [btff_pkg::ADDR_W-1:0] fa, output bit g,
                                   output bit [btff_pkg::ADDR_W-1:0] a);
            if (op == btff_pkg::OP_ALLOC)
            begin
                allocate(req, g, a);
            end
            else
            begin
                g = release_block(fa);
                a = '0;
            end
            granted_q.push_back(g);
            address_q.push_back(a);
        endfunction

        function void check_result(bit g, bit [btff_pkg::ADDR_W-1:0] a);
            bit                        eg;
            bit [btff_pkg::ADDR_W-1:0] ea;
            if (granted_q.size() == 0)
            begin
                $display("%0t: unexpected result granted=%0b address=%h", $time, g, a);
                errors++;
                return;
            end
            eg = granted_q.pop_front();
            ea = address_q.pop_front();
            if (g !== eg)
            begin
                $display("%0t: granted expected %0b actual %0b", $time, eg, g);
                errors++;
            end
            if (a !== ea)
            begin
                $display("%0t: payload_address expected %h actual %h", $time, ea, a);
                errors++;
            end
        endfunction
    endclass

    logic                          clk;
    logic                          rst_n;
    logic                          start;
    logic                          busy;
    logic                          opcode;
    logic [btff_pkg::REQ_W-1:0]    request_size;
    logic [btff_pkg::ADDR_W-1:0]   free_address;
    logic                          done;
    logic                          granted;
    logic [btff_pkg::ADDR_W-1:0]   payload_address;
    logic                          psel;
    logic                          penable;
    logic                          pwrite;
    logic [btff_pkg::PADDR_W-1:0]  paddr;
    logic [31:0]                   pwdata;
    logic [31:0]                   prdata;
    logic                          pready;

    alloc_scoreboard    heap_sb;
    int unsigned        live_off [$];
    int unsigned        cycles;

    boundary_tag_first_fit_allocator uut (.*);

    always
    begin
        clk = 1'b1;
        #2;
        clk = 1'b0;
        #2;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && done) heap_sb.check_result(granted, payload_address);
    end

    // Start stays high across back-to-back requests; only gaps lower it.
    task automatic send_request(btff_pkg::opcode_t op, logic [btff_pkg::REQ_W-1:0] req,
                                logic [btff_pkg::ADDR_W-1:0] fa);
        bit                        g;
        bit [btff_pkg::ADDR_W-1:0] a;
        @(negedge clk);
        start        <= 1'b1;
        opcode       <= op;
        request_size <= req;
        free_address <= fa;
        do @(posedge clk); while (busy);
        heap_sb.note_request(op, req, fa, g, a);
        if (op == btff_pkg::OP_ALLOC && g) live_off.push_back(a - heap_sb.base);
    endtask

    task automatic pause(int n);
        @(negedge clk);
        start <= 1'b0;
        repeat (n - 1) @(negedge clk);
    endtask

    task automatic drain();
        pause(1);
        while (heap_sb.granted_q.size() != 0) @(posedge clk);
        repeat (SETTLE) @(posedge clk);
        while (busy) @(posedge clk);
    endtask

    task automatic write_base(logic [31:0] value);
        @(negedge clk);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= '0;
        pwdata  <= value;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        heap_sb.base = value;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic free_live(int idx);
        int unsigned off;
        off = live_off[idx];
        live_off.delete(idx);
        send_request(btff_pkg::OP_FREE, '0, heap_sb.base + off);
    endtask

    task automatic random_request();
        int unsigned                pick;
        int unsigned                off;
        logic [btff_pkg::REQ_W-1:0] req;
        pick = $urandom_range(0, 99);
        if (pick < 45 || (pick < 85 && live_off.size() == 0))
        begin
            if ($urandom_range(0, 19) == 0) req = btff_pkg::REQ_W'($urandom);
            else if ($urandom_range(0, 9) == 0) req = btff_pkg::REQ_W'($urandom_range(0, 4096));
            else req = btff_pkg::REQ_W'($urandom_range(0, 160));
            send_request(btff_pkg::OP_ALLOC, req, btff_pkg::ADDR_W'($urandom));
        end
        else if (pick < 85)
        begin
            free_live($urandom_range(0, live_off.size() - 1));
        end
        else if (pick < 92)
        begin
            // Near-miss addresses: stale, misaligned or inside a block.
            off = $urandom_range(0, btff_pkg::HEAP_BYTES + 16);
            send_request(btff_pkg::OP_FREE, btff_pkg::REQ_W'($urandom), heap_sb.base + off);
        end
        else
        begin
            send_request(btff_pkg::OP_FREE, btff_pkg::REQ_W'($urandom),
                         btff_pkg::ADDR_W'($urandom));
        end
    endtask

    task automatic random_phase(int count, bit with_gaps);
        for (int i = 0; i < count; i++)
        begin
            if (with_gaps && $urandom_range(0, 3) == 0) pause($urandom_range(1, 8));
            random_request();
        end
    endtask

    initial
    begin
        heap_sb = new();
        heap_sb.clear_heap();
        heap_sb.base = '0;
        cycles       = 0;
        rst_n        = 1'b0;
        start        = 1'b0;
        opcode       = btff_pkg::OP_ALLOC;
        request_size = '0;
        free_address = '0;
        psel         = 1'b0;
        penable      = 1'b0;
        pwrite       = 1'b0;
        paddr        = '0;
        pwdata       = '0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        while (busy) @(posedge clk);

        write_base(32'h0000_0000);
        send_request(btff_pkg::OP_ALLOC, 13'd0, '0);
        send_request(btff_pkg::OP_ALLOC, 13'd4096, '0);
        send_request(btff_pkg::OP_ALLOC, 13'h1FFF, '0);
        send_request(btff_pkg::OP_ALLOC, 13'd1, '0);
        send_request(btff_pkg::OP_ALLOC, 13'd8, '0);
        send_request(btff_pkg::OP_ALLOC, 13'd9, '0);
        send_request(btff_pkg::OP_ALLOC, 13'd40, '0);
        send_request(btff_pkg::OP_FREE, '0, live_off[2] + 4);
        send_request(btff_pkg::OP_FREE, '0, live_off[3] + 8);
        send_request(btff_pkg::OP_FREE, '0, 32'd5000);
        send_request(btff_pkg::OP_FREE, '0, 32'hFFFF_FFFF);
        send_request(btff_pkg::OP_FREE, '0, live_off[1]);
        send_request(btff_pkg::OP_FREE, '0, live_off[1]);
        live_off.delete(1);
        free_live(0);
        free_live(1);
        while (live_off.size() != 0) free_live(0);
        send_request(btff_pkg::OP_ALLOC, 13'd4081, '0);
        send_request(btff_pkg::OP_ALLOC, 13'd4080, '0);
        free_live(0);
        send_request(btff_pkg::OP_ALLOC, 13'd4064, '0);
        free_live(0);

        random_phase(110, 1'b1);
        drain();
        write_base(32'hFFFF_F800);
        random_phase(110, 1'b1);
        drain();
        write_base($urandom);
        random_phase(100, 1'b1);
        drain();
        write_base(32'hFFFF_FFFF);
        random_phase(80, 1'b0);
        drain();

        if (heap_sb.errors == 0 && heap_sb.granted_q.size() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
